>>> hw/rtl/c2u_pkg.sv
// shared types, constants and the month length function for the calendar to unix seconds block
package c2u_pkg;

  localparam int EPOCH_YEAR    = 1970;
  localparam int EPOCH_MOD100  = 70;
  localparam int EPOCH_MOD400  = 370;
  localparam int SECS_PER_DAY  = 86400;
  localparam int SECS_PER_HOUR = 3600;
  localparam int SECS_PER_MIN  = 60;
  localparam int MONTHS        = 12;

  localparam int YEAR_W   = 12;
  localparam int MONTH_W  = 4;
  localparam int DAY_W    = 5;
  localparam int HOUR_W   = 5;
  localparam int MINUTE_W = 6;
  localparam int SECOND_W = 6;
  localparam int TOD_W    = 17;
  localparam int OUT_W    = 33;
  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 40;

  localparam logic [MONTH_W-1:0] FEB = 4'd2;
  localparam logic [MONTH_W-1:0] APR = 4'd4;
  localparam logic [MONTH_W-1:0] JUN = 4'd6;
  localparam logic [MONTH_W-1:0] SEP = 4'd9;
  localparam logic [MONTH_W-1:0] NOV = 4'd11;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_YEARS,
    ST_MONTHS,
    ST_SCALE,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic load;
    logic year_step;
    logic month_step;
    logic scale;
    logic finish;
  } c2u_cmd_t;

  typedef struct packed {
    logic years_done;
    logic months_done;
    logic out_full;
  } c2u_sts_t;

  function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
                                                 input logic leap);
    logic [DAY_W-1:0] len;
    case (m) inside
      APR, JUN, SEP, NOV: len = 5'd30;
      FEB:                len = leap ? 5'd29 : 5'd28;
      default:            len = 5'd31;
    endcase
    return len;
  endfunction

endpackage

>>> hw/rtl/c2u_ctrl.sv
// controller state machine sequencing the year loop, month loop, scaling and result load
module c2u_ctrl
  import c2u_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  input  c2u_sts_t sts,
  output c2u_cmd_t cmd
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) state_next = ST_YEARS;
      end
      ST_YEARS: begin
        if (sts.years_done) state_next = ST_MONTHS;
      end
      ST_MONTHS: begin
        if (sts.months_done) state_next = ST_SCALE;
      end
      ST_SCALE: begin
        state_next = ST_FINISH;
      end
      ST_FINISH: begin
        if (!sts.out_full) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready = !rst;
        cmd.load = in_valid && !rst;
      end
      ST_YEARS: begin
        cmd.year_step = !sts.years_done;
      end
      ST_MONTHS: begin
        cmd.month_step = !sts.months_done;
      end
      ST_SCALE: begin
        cmd.scale = 1'b1;
      end
      ST_FINISH: begin
        cmd.finish = !sts.out_full;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

>>> hw/rtl/c2u_dp.sv
// datapath: day accumulator, leap tracking counters, scaling multiply and output register
module c2u_dp
  import c2u_pkg::*;
#(
  parameter int YEAR_SPAN = 256
) (
  input  logic                   clk,
  input  logic                   rst,
  input  c2u_cmd_t               cmd,
  output c2u_sts_t               sts,
  input  logic [IN_TDATA_W-1:0]  in_data,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [OUT_W-1:0]       out_secs,
  output logic                   out_invalid
);

  localparam int YEAR_END = EPOCH_YEAR + YEAR_SPAN;
  localparam int DAYS_W   = $clog2(YEAR_SPAN * 366 + 400);
  localparam int PROD_W   = DAYS_W + 17;
  localparam int SUM_W    = (PROD_W > OUT_W) ? PROD_W : OUT_W;

  logic [YEAR_W-1:0]   in_year;
  logic [MONTH_W-1:0]  in_month;
  logic [DAY_W-1:0]    in_day;
  logic [HOUR_W-1:0]   in_hour;
  logic [MINUTE_W-1:0] in_minute;
  logic [SECOND_W-1:0] in_second;
  logic                bad;

  logic [DAYS_W-1:0]   days;
  logic [YEAR_W-1:0]   years_left;
  logic [6:0]          mod100;
  logic [8:0]          mod400;
  logic [MONTH_W-1:0]  month;
  logic [MONTH_W-1:0]  month_cnt;
  logic [HOUR_W-1:0]   hour;
  logic [MINUTE_W-1:0] minute;
  logic [SECOND_W-1:0] second;
  logic                invalid;
  logic [PROD_W-1:0]   prod;
  logic [TOD_W-1:0]    tod;
  logic                leap;
  logic [SUM_W-1:0]    total;

  assign in_year   = in_data[11:0];
  assign in_month  = in_data[15:12];
  assign in_day    = in_data[20:16];
  assign in_hour   = in_data[25:21];
  assign in_minute = in_data[31:26];
  assign in_second = in_data[37:32];

  assign bad = (in_month == '0) || (32'(in_month) > MONTHS) || (in_day == '0) ||
               (32'(in_year) < EPOCH_YEAR) || (32'(in_year) >= YEAR_END);

  // leap rule from the running remainders of the year counter
  assign leap = ((mod400[1:0] == 2'd0) && (mod100 != 7'd0)) || (mod400 == 9'd0);

  assign total = SUM_W'(prod) + SUM_W'(tod);

  assign sts.years_done  = (years_left == '0);
  assign sts.months_done = (month_cnt >= month);
  assign sts.out_full    = out_valid && !out_ready;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      days   <= DAYS_W'(in_day - 5'd1);
      mod100 <= 7'(EPOCH_MOD100);
      mod400 <= 9'(EPOCH_MOD400);
      month_cnt <= 4'd1;
      hour   <= in_hour;
      minute <= in_minute;
      second <= in_second;
      invalid <= bad;
      if (bad) begin
        years_left <= '0;
        month      <= 4'd1;
      end else begin
        years_left <= YEAR_W'(32'(in_year) - EPOCH_YEAR);
        month      <= in_month;
      end
    end else if (cmd.year_step) begin
      days       <= days + (leap ? DAYS_W'(366) : DAYS_W'(365));
      years_left <= years_left - 1'b1;
      mod100     <= (mod100 == 7'd99) ? 7'd0 : mod100 + 7'd1;
      mod400     <= (mod400 == 9'd399) ? 9'd0 : mod400 + 9'd1;
    end else if (cmd.month_step) begin
      days      <= days + DAYS_W'(month_len(month_cnt, leap));
      month_cnt <= month_cnt + 4'd1;
    end
    if (cmd.scale) begin
      prod <= PROD_W'(days) * PROD_W'(SECS_PER_DAY);
      tod  <= TOD_W'(hour) * TOD_W'(SECS_PER_HOUR) +
              TOD_W'(minute) * TOD_W'(SECS_PER_MIN) + TOD_W'(second);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.finish) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_secs    <= invalid ? '0 : OUT_W'(total);
      out_invalid <= invalid;
    end
  end

endmodule

>>> hw/rtl/calendar_to_unix_seconds.sv
// the controller steps the year loop, month loop, scaling and result load per input transaction
// the day accumulator steps once per elapsed year and once per earlier month
// one transaction in flight; the next input is accepted once the result register takes the result
// the result register holds a waiting output while the next input is accepted
// rst is synchronous active high and clears the controller and the output valid
module calendar_to_unix_seconds
  import c2u_pkg::*;
#(
  parameter int YEAR_SPAN = 256
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,  // year, month, day, hour, minute, second, pad
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,  // unix_seconds, pad
  output logic [0:0]             m_axis_tuser   // invalid
);

  c2u_cmd_t         cmd;
  c2u_sts_t         sts;
  logic [OUT_W-1:0] secs;
  logic             invalid;

  c2u_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  c2u_dp #(
    .YEAR_SPAN (YEAR_SPAN)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .sts         (sts),
    .in_data     (s_axis_tdata),
    .out_valid   (m_axis_tvalid),
    .out_ready   (m_axis_tready),
    .out_secs    (secs),
    .out_invalid (invalid)
  );

  assign m_axis_tdata = {(OUT_TDATA_W - OUT_W)'(0), secs};
  assign m_axis_tuser = invalid;

endmodule

>>> hw/rtl/c2u_chk.sv
// port level checker for the calendar to unix seconds block and its bind
module c2u_chk
  import c2u_pkg::*;
(
  input logic                   clk,
  input logic                   rst,
  input logic                   s_axis_tvalid,
  input logic                   s_axis_tready,
  input logic [IN_TDATA_W-1:0]  s_axis_tdata,
  input logic                   m_axis_tvalid,
  input logic                   m_axis_tready,
  input logic [OUT_TDATA_W-1:0] m_axis_tdata,
  input logic [0:0]             m_axis_tuser
);

  // flagged results carry a zero count
  a_invalid_zero: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tuser[0]) |-> (m_axis_tdata == '0))
    else $error("invalid result with nonzero seconds");

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata) &&
                                           $stable(m_axis_tuser)))
    else $error("stalled result changed");

  // busy after an input transaction
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("input accepted while still working");

  // a new result is only loaded while the input side is closed
  a_result_from_work: assert property (@(posedge clk) disable iff (rst)
    $rose(m_axis_tvalid) |-> $past(!s_axis_tready))
    else $error("result appeared without work in progress");

endmodule

bind calendar_to_unix_seconds c2u_chk u_c2u_chk (.*);

>>> bench/tb_calendar_to_unix_seconds.sv
// self-checking testbench for the calendar to unix seconds converter
module tb_calendar_to_unix_seconds;
  import c2u_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int YEAR_SPAN      = 256;
  localparam int RANDOM_ITEMS   = 1700;
  localparam int PHASES         = 4;
  localparam int STALL_LIMIT    = 4000;
  localparam int DRAIN_CYCLES   = 300;
  localparam int RESET_CYCLES   = 7;

  typedef struct packed {
    logic [YEAR_W-1:0]   year;
    logic [MONTH_W-1:0]  month;
    logic [DAY_W-1:0]    day;
    logic [HOUR_W-1:0]   hour;
    logic [MINUTE_W-1:0] minute;
    logic [SECOND_W-1:0] second;
  } reading_t;

  typedef struct packed {
    logic [OUT_W-1:0] secs;
    logic             invalid;
  } epoch_result_t;

  typedef struct packed {
    reading_t      rd;
    logic          known;
    epoch_result_t res;
  } stim_row_t;

  logic                   clk = 1'b0;
  logic                   rst;
  logic                   s_axis_tvalid;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic [0:0]             m_axis_tuser;

  epoch_result_t pending_results[$];
  stim_row_t     directed_rows[$];
  int unsigned   month_days[12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
  int            sender_idle_pct = 0;
  int            sink_stall_pct  = 0;
  int            mismatches      = 0;
  int            results_seen    = 0;
  int            invalid_seen    = 0;
  int            readings_sent   = 0;
  int            quiet_cycles    = 0;

  calendar_to_unix_seconds #(
    .YEAR_SPAN(YEAR_SPAN)
  ) uut (
    .clk(clk),
    .rst(rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .m_axis_tuser(m_axis_tuser)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic bit gregorian_leap(int unsigned y);
    return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
  endfunction

  function automatic epoch_result_t calendar_seconds(reading_t r);
    epoch_result_t     res;
    longint unsigned   days;
    longint unsigned   total;
    int unsigned       k;
    days = 0;
    res = '0;
    if (r.month < 1 || r.month > MONTHS || r.day == 0 || r.year < EPOCH_YEAR ||
        r.year >= EPOCH_YEAR + YEAR_SPAN) begin
      res.invalid = 1'b1;
      return res;
    end
    for (k = EPOCH_YEAR; k < r.year; k++) days += gregorian_leap(k) ? 366 : 365;
    for (k = 1; k < r.month; k++) begin
      if (k == 2 && gregorian_leap(r.year)) days += 29;
      else days += month_days[k-1];
    end
    days += r.day - 1;
    total = days * SECS_PER_DAY + longint'(r.hour) * SECS_PER_HOUR
          + longint'(r.minute) * SECS_PER_MIN + longint'(r.second);
    res.secs = total[OUT_W-1:0];
    return res;
  endfunction

  function automatic stim_row_t mk_row(int y, int mo, int d, int h, int mi, int s,
                                       bit known, longint unsigned secs, bit inv);
    stim_row_t row;
    row.rd.year        = YEAR_W'(y);
    row.rd.month       = MONTH_W'(mo);
    row.rd.day         = DAY_W'(d);
    row.rd.hour        = HOUR_W'(h);
    row.rd.minute      = MINUTE_W'(mi);
    row.rd.second      = SECOND_W'(s);
    row.known          = known;
    row.res.secs       = secs[OUT_W-1:0];
    row.res.invalid    = inv;
    return row;
  endfunction

  function automatic reading_t random_reading();
    reading_t r;
    int       pick;
    pick = $urandom_range(99);
    if (pick < 60) r.year = YEAR_W'($urandom_range(EPOCH_YEAR + 40, EPOCH_YEAR));
    else if (pick < 78)
      r.year = YEAR_W'($urandom_range(EPOCH_YEAR + YEAR_SPAN - 1, EPOCH_YEAR));
    else if (pick < 84) r.year = YEAR_W'($urandom_range(2225, 2048));
    else if (pick < 92) r.year = YEAR_W'($urandom_range(EPOCH_YEAR - 1, 0));
    else r.year = YEAR_W'($urandom_range(2225, 0));
    if ($urandom_range(9) == 0) begin
      r.month = MONTH_W'($urandom_range(15, 0));
      r.day   = DAY_W'($urandom_range(31, 0));
    end else begin
      r.month = MONTH_W'($urandom_range(12, 1));
      r.day   = DAY_W'($urandom_range(31, 1));
    end
    if ($urandom_range(19) == 0) begin
      r.hour   = HOUR_W'($urandom_range(31, 0));
      r.minute = MINUTE_W'($urandom_range(63, 0));
      r.second = SECOND_W'($urandom_range(63, 0));
    end else begin
      r.hour   = HOUR_W'($urandom_range(23, 0));
      r.minute = MINUTE_W'($urandom_range(59, 0));
      r.second = SECOND_W'($urandom_range(59, 0));
    end
    return r;
  endfunction

  task automatic send_reading(reading_t r, epoch_result_t want);
    while ($urandom_range(99) < sender_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= IN_TDATA_W'({r.second, r.minute, r.hour, r.day, r.month, r.year});
    do @(posedge clk); while (!s_axis_tready);
    pending_results.push_back(want);
    readings_sent++;
  endtask

  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  always @(posedge clk) begin
    m_axis_tready <= rst ? 1'b0 : ($urandom_range(99) >= sink_stall_pct);
  end

  always @(posedge clk) begin
    epoch_result_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected result, actual seconds=%0d invalid=%0b", $time,
                 m_axis_tdata[OUT_W-1:0], m_axis_tuser[0]);
      end else begin
        want = pending_results.pop_front();
        if (want.invalid) invalid_seen++;
        if (m_axis_tdata[OUT_W-1:0] !== want.secs) begin
          mismatches++;
          $display("%0t: seconds mismatch, expected=%0d actual=%0d", $time,
                   want.secs, m_axis_tdata[OUT_W-1:0]);
        end
        if (m_axis_tuser[0] !== want.invalid) begin
          mismatches++;
          $display("%0t: invalid flag mismatch, expected=%0b actual=%0b", $time,
                   want.invalid, m_axis_tuser[0]);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles == STALL_LIMIT) begin
      $display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    int          phase;
    int          n;
    int          idle_pct[PHASES];
    int          stall_pct[PHASES];
    stim_row_t   row;
    idle_pct      = '{0, 54, 0, 6};
    stall_pct     = '{0, 0, 54, 6};
    rst           = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    m_axis_tready = 1'b0;

    // epoch, extremes, range errors, leap rules, unchecked day and time fields
    directed_rows.push_back(mk_row(1970, 1, 1, 0, 0, 0, 1, 0, 0));
    directed_rows.push_back(mk_row(1970, 1, 1, 23, 59, 59, 1, 86399, 0));
    directed_rows.push_back(mk_row(1970, 1, 2, 0, 0, 0, 1, 86400, 0));
    directed_rows.push_back(mk_row(2225, 12, 31, 23, 59, 59, 1, 64'd8078572799, 0));
    directed_rows.push_back(mk_row(2038, 1, 19, 3, 14, 8, 1, 64'd2147483648, 0));
    directed_rows.push_back(mk_row(1969, 12, 31, 23, 59, 59, 1, 0, 1));
    directed_rows.push_back(mk_row(0, 1, 1, 0, 0, 0, 1, 0, 1));
    directed_rows.push_back(mk_row(2226, 1, 1, 0, 0, 0, 1, 0, 1));
    directed_rows.push_back(mk_row(2000, 0, 1, 0, 0, 0, 1, 0, 1));
    directed_rows.push_back(mk_row(2000, 13, 1, 0, 0, 0, 1, 0, 1));
    directed_rows.push_back(mk_row(2000, 15, 31, 31, 63, 63, 1, 0, 1));
    directed_rows.push_back(mk_row(2000, 6, 0, 12, 0, 0, 1, 0, 1));
    directed_rows.push_back(mk_row(1536, 6, 15, 0, 0, 0, 1, 0, 1));
    directed_rows.push_back(mk_row(2000, 2, 29, 12, 30, 30, 0, 0, 0));
    directed_rows.push_back(mk_row(2000, 3, 1, 0, 0, 0, 0, 0, 0));
    directed_rows.push_back(mk_row(2100, 3, 1, 0, 0, 0, 0, 0, 0));
    directed_rows.push_back(mk_row(1972, 3, 1, 0, 0, 0, 0, 0, 0));
    directed_rows.push_back(mk_row(2001, 2, 31, 8, 0, 0, 0, 0, 0));
    directed_rows.push_back(mk_row(1970, 12, 31, 23, 59, 59, 0, 0, 0));
    directed_rows.push_back(mk_row(2225, 12, 31, 31, 63, 63, 0, 0, 0));
    directed_rows.push_back(mk_row(2047, 11, 30, 16, 32, 32, 0, 0, 0));
    directed_rows.push_back(mk_row(2048, 4, 16, 15, 31, 31, 0, 0, 0));
    directed_rows.push_back(mk_row(1999, 12, 31, 23, 59, 59, 0, 0, 0));

    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_rows[i]) begin
      row = directed_rows[i];
      send_reading(row.rd, row.known ? row.res : calendar_seconds(row.rd));
    end
    drain_results();

    for (phase = 0; phase < PHASES; phase++) begin
      sender_idle_pct = idle_pct[phase];
      sink_stall_pct  = stall_pct[phase];
      for (n = 0; n < RANDOM_ITEMS / PHASES; n++) begin
        row.rd = random_reading();
        send_reading(row.rd, calendar_seconds(row.rd));
      end
      drain_results();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("sent %0d clock readings (%0d directed), checked %0d results, %0d flagged invalid",
             readings_sent, directed_rows.size(), results_seen, invalid_seen);
    $display("idle and stall mixes covered in %0d phases, mismatches: %0d", PHASES,
             mismatches);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

>>> calendar_to_unix_seconds.f
hw/rtl/c2u_pkg.sv
hw/rtl/c2u_ctrl.sv
hw/rtl/c2u_dp.sv
hw/rtl/calendar_to_unix_seconds.sv
hw/rtl/c2u_chk.sv
bench/tb_calendar_to_unix_seconds.sv
